/* hdl/lcfc_pkg.sv */
`default_nettype none
package lcfc_pkg;

  // default build values
  localparam int LED_COUNT_DEF        = 4;
  localparam int TICKS_PER_SECOND_DEF = 4;

  // fixed field widths
  localparam int SID_W   = 16;
  localparam int ADDR_W  = 8;
  localparam int DEV_W   = 7;
  localparam int BYTE_W  = 8;
  localparam int SHOWN_LEDS = 4;
  localparam int CFG_W   = 16;
  localparam int CFG_IDX_W = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SECURITY_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DEVICE_ADDRESS = 1'd1;

  // reset values of the configuration registers
  localparam logic [SID_W-1:0] SID_RESET  = 16'hFFFF;
  localparam logic [DEV_W-1:0] DEV_RESET  = 7'd1;

  // frame matching constants
  localparam logic [SID_W-1:0]  SID_WILDCARD   = 16'hFFFF;
  localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 8'hFF;

  // operation codes in the high nibble of the command
  localparam logic [3:0] OP_BLINK    = 4'd1;
  localparam logic [3:0] OP_STOP     = 4'd2;
  localparam logic [3:0] OP_STEADY   = 4'd3;
  localparam logic [3:0] OP_STOP_ALT = 4'd4;

  // led timer
  localparam int TIMER_W = 10;
  localparam logic [TIMER_W-1:0] TIMER_MAX = 10'd1023;
  localparam int STEADY_PROD_W = 18;

  // per-item action handed to every led
  typedef struct packed {
    logic tick;
    logic stop;
    logic blink;
    logic steady;
  } lcfc_op_t;

endpackage
`default_nettype wire

/* hdl/lcfc_frame_check.sv */
`default_nettype none
module lcfc_frame_check (
  input  wire logic                          func,
  input  wire logic [lcfc_pkg::SID_W-1:0]    security_id,
  input  wire logic [lcfc_pkg::ADDR_W-1:0]   address,
  input  wire logic [lcfc_pkg::BYTE_W-1:0]   command,
  input  wire logic [lcfc_pkg::SID_W-1:0]    my_security_id,
  input  wire logic [lcfc_pkg::DEV_W-1:0]    my_device_address,
  output lcfc_pkg::lcfc_op_t                 op,
  output logic                               accepted,
  output logic                               ack
);

  logic       id_ok;
  logic       addr_ok;
  logic [3:0] opcode;

  // security id and address filter
  assign id_ok   = (security_id == my_security_id) ||
                   (security_id == lcfc_pkg::SID_WILDCARD);
  assign addr_ok = (address == lcfc_pkg::ADDR_BROADCAST) || address[lcfc_pkg::ADDR_W-1] ||
                   (address == {1'b0, my_device_address});
  assign accepted = !func && id_ok && addr_ok;
  assign ack      = accepted && (address != lcfc_pkg::ADDR_BROADCAST);

  // command decode
  assign opcode    = command[7:4];
  assign op.tick   = func;
  assign op.stop   = accepted && ((opcode == lcfc_pkg::OP_BLINK) ||
                                  (opcode == lcfc_pkg::OP_STOP) ||
                                  (opcode == lcfc_pkg::OP_STEADY) ||
                                  (opcode == lcfc_pkg::OP_STOP_ALT));
  assign op.blink  = accepted && (opcode == lcfc_pkg::OP_BLINK);
  assign op.steady = accepted && (opcode == lcfc_pkg::OP_STEADY);

endmodule
`default_nettype wire

/* hdl/lcfc_led.sv */
`default_nettype none
module lcfc_led #(
  parameter int TICKS_PER_SECOND = lcfc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        en,
  input  wire lcfc_pkg::lcfc_op_t          op,
  input  wire logic                        sel,
  input  wire logic [lcfc_pkg::BYTE_W-1:0] par,
  output logic                             lit_nxt
);

  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_BLINK  = 2'd1;
  localparam logic [1:0] MODE_STEADY = 2'd2;

  logic [1:0]                     mode_r, mode_nxt;
  logic                           lit_r;
  logic [lcfc_pkg::TIMER_W-1:0]   timer_r, timer_nxt;
  logic [2:0]                     remaining_r, remaining_nxt;
  logic                           forever_r, forever_nxt;
  logic [1:0]                     on_ticks_r, on_ticks_nxt;
  logic [2:0]                     off_factor_r, off_factor_nxt;

  logic [2:0]                         on_cnt;
  logic [5:0]                         off_ticks;
  logic [2:0]                         rem_dec;
  logic [lcfc_pkg::STEADY_PROD_W-1:0] steady_prod;
  logic [lcfc_pkg::TIMER_W-1:0]       steady_ticks;

  // blink phase lengths
  assign on_cnt    = {1'b0, on_ticks_r} + 3'd1;
  assign off_ticks = 6'({3'b0, on_cnt} * ({3'b0, off_factor_r} + 6'd1));
  assign rem_dec   = remaining_r - 3'd1;

  // steady hold time in ticks, saturated
  assign steady_prod = lcfc_pkg::STEADY_PROD_W'(par) *
                       lcfc_pkg::STEADY_PROD_W'(TICKS_PER_SECOND);
  assign steady_ticks = (steady_prod > lcfc_pkg::STEADY_PROD_W'(lcfc_pkg::TIMER_MAX)) ?
                        lcfc_pkg::TIMER_MAX : steady_prod[lcfc_pkg::TIMER_W-1:0];

  // next state for one item
  always_comb begin
    mode_nxt       = mode_r;
    lit_nxt        = lit_r;
    timer_nxt      = timer_r;
    remaining_nxt  = remaining_r;
    forever_nxt    = forever_r;
    on_ticks_nxt   = on_ticks_r;
    off_factor_nxt = off_factor_r;
    if (op.tick) begin
      if (mode_r != MODE_IDLE) begin
        if (timer_r > lcfc_pkg::TIMER_W'(1)) begin
          timer_nxt = timer_r - lcfc_pkg::TIMER_W'(1);
        end else begin
          timer_nxt = '0;
          if (mode_r == MODE_STEADY) begin
            mode_nxt = MODE_IDLE;
            lit_nxt  = 1'b0;
          end else if (lit_r) begin
            lit_nxt   = 1'b0;
            timer_nxt = lcfc_pkg::TIMER_W'(off_ticks);
          end else if (!forever_r && (rem_dec == 3'd0)) begin
            remaining_nxt = rem_dec;
            mode_nxt      = MODE_IDLE;
          end else begin
            if (!forever_r) begin
              remaining_nxt = rem_dec;
            end
            lit_nxt   = 1'b1;
            timer_nxt = lcfc_pkg::TIMER_W'(on_cnt);
          end
        end
      end
    end else begin
      if (op.stop) begin
        mode_nxt       = MODE_IDLE;
        lit_nxt        = 1'b0;
        timer_nxt      = '0;
        remaining_nxt  = '0;
        forever_nxt    = 1'b0;
        on_ticks_nxt   = '0;
        off_factor_nxt = '0;
      end
      if (sel && op.blink) begin
        mode_nxt       = MODE_BLINK;
        on_ticks_nxt   = par[7:6];
        off_factor_nxt = par[5:3];
        remaining_nxt  = par[2:0];
        forever_nxt    = (par[2:0] == 3'd0);
        lit_nxt        = 1'b1;
        timer_nxt      = lcfc_pkg::TIMER_W'({1'b0, par[7:6]} + 3'd1);
      end
      if (sel && op.steady) begin
        if (steady_ticks == '0) begin
          mode_nxt  = MODE_IDLE;
          lit_nxt   = 1'b0;
          timer_nxt = '0;
        end else begin
          mode_nxt  = MODE_STEADY;
          lit_nxt   = 1'b1;
          timer_nxt = steady_ticks;
        end
      end
    end
  end

  // led state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r       <= MODE_IDLE;
      lit_r        <= 1'b0;
      timer_r      <= '0;
      remaining_r  <= '0;
      forever_r    <= 1'b0;
      on_ticks_r   <= '0;
      off_factor_r <= '0;
    end else if (en) begin
      mode_r       <= mode_nxt;
      lit_r        <= lit_nxt;
      timer_r      <= timer_nxt;
      remaining_r  <= remaining_nxt;
      forever_r    <= forever_nxt;
      on_ticks_r   <= on_ticks_nxt;
      off_factor_r <= off_factor_nxt;
    end
  end

endmodule
`default_nettype wire

/* hdl/led_command_frame_controller.sv */
// LED command frame controller
// Input channel (in_valid / in_stall) carries one item per handshake: either a
// received command frame (in_func = 0) or one 250 ms time tick (in_func = 1).
// Output channel (out_valid / out_stall) returns exactly one result item per
// input item, in order: the LED drive after the item, the frame accept flag
// and the acknowledgement fields (zero when no acknowledgement is due).
// Configuration (cfg_we, cfg_index, cfg_data) sets the own security ID
// (index 0) and the own device address (index 1); write only while idle.
// An accepted item is captured in the input register, and its result is
// registered in the result register when the input register advances, which
// waits while the receiver stalls. One item is taken per cycle while the
// receiver does not stall; the whole LED state update is a single pass of
// logic between the input register and the result register.
// When the receiver stalls, the result is held and the input register keeps
// one more item; in_stall rises only when both are full.
// Reset (rst_n low, synchronous) empties both stages, sets the security ID to
// 0xFFFF, the device address to 1 and puts every LED idle and dark.
`default_nettype none
module led_command_frame_controller #(
  parameter int LED_COUNT        = lcfc_pkg::LED_COUNT_DEF,
  parameter int TICKS_PER_SECOND = lcfc_pkg::TICKS_PER_SECOND_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [lcfc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lcfc_pkg::CFG_W-1:0]     cfg_data,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_func,
  input  wire logic [lcfc_pkg::SID_W-1:0]     in_security_id,
  input  wire logic [lcfc_pkg::ADDR_W-1:0]    in_address,
  input  wire logic [lcfc_pkg::BYTE_W-1:0]    in_seq,
  input  wire logic [lcfc_pkg::BYTE_W-1:0]    in_command,
  input  wire logic [lcfc_pkg::BYTE_W-1:0]    in_parameter_req,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [lcfc_pkg::SHOWN_LEDS-1:0]     out_led_on,
  output logic                                out_frame_accepted,
  output logic                                out_ack_valid,
  output logic [lcfc_pkg::SID_W-1:0]          out_ack_security_id,
  output logic [lcfc_pkg::BYTE_W-1:0]         out_ack_seq,
  output logic [lcfc_pkg::BYTE_W-1:0]         out_ack_parameter
);

  // configuration registers
  logic [lcfc_pkg::SID_W-1:0] my_sid_r;
  logic [lcfc_pkg::DEV_W-1:0] my_dev_r;

  // input register
  logic                        s1_valid_r;
  logic                        s1_func_r;
  logic [lcfc_pkg::SID_W-1:0]  s1_sid_r;
  logic [lcfc_pkg::ADDR_W-1:0] s1_addr_r;
  logic [lcfc_pkg::BYTE_W-1:0] s1_seq_r;
  logic [lcfc_pkg::BYTE_W-1:0] s1_cmd_r;
  logic [lcfc_pkg::BYTE_W-1:0] s1_par_r;

  // result register
  logic                            out_valid_r;
  logic [lcfc_pkg::SHOWN_LEDS-1:0] led_on_r;
  logic                            accepted_r;
  logic                            ack_r;
  logic [lcfc_pkg::SID_W-1:0]      ack_sid_r;
  logic [lcfc_pkg::BYTE_W-1:0]     ack_seq_r;
  logic [lcfc_pkg::BYTE_W-1:0]     ack_par_r;

  logic                            out_ready;
  logic                            adv;
  logic                            in_take;
  lcfc_pkg::lcfc_op_t              op;
  logic                            accepted;
  logic                            ack;
  logic [LED_COUNT-1:0]            lit_nxt;
  logic [lcfc_pkg::SHOWN_LEDS-1:0] led_on_nxt;

  // handshake
  assign out_ready = !out_valid_r || !out_stall;
  assign adv       = s1_valid_r && out_ready;
  assign in_stall  = s1_valid_r && !out_ready;
  assign in_take   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_sid_r <= lcfc_pkg::SID_RESET;
      my_dev_r <= lcfc_pkg::DEV_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        lcfc_pkg::REG_SECURITY_ID:    my_sid_r <= cfg_data;
        lcfc_pkg::REG_DEVICE_ADDRESS: my_dev_r <= cfg_data[lcfc_pkg::DEV_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_take) begin
      s1_valid_r <= 1'b1;
    end else if (adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_func_r <= in_func;
      s1_sid_r  <= in_security_id;
      s1_addr_r <= in_address;
      s1_seq_r  <= in_seq;
      s1_cmd_r  <= in_command;
      s1_par_r  <= in_parameter_req;
    end
  end

  // frame filter and command decode
  lcfc_frame_check u_check (
    .func              (s1_func_r),
    .security_id       (s1_sid_r),
    .address           (s1_addr_r),
    .command           (s1_cmd_r),
    .my_security_id    (my_sid_r),
    .my_device_address (my_dev_r),
    .op                (op),
    .accepted          (accepted),
    .ack               (ack)
  );

  // one timer per led; only the low four leds take mask bits
  for (genvar i = 0; i < LED_COUNT; i++) begin : g_led
    logic sel;
    if (i < lcfc_pkg::SHOWN_LEDS) begin : g_sel
      assign sel = s1_cmd_r[i];
    end else begin : g_nosel
      assign sel = 1'b0;
    end
    lcfc_led #(
      .TICKS_PER_SECOND (TICKS_PER_SECOND)
    ) u_led (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (adv),
      .op      (op),
      .sel     (sel),
      .par     (s1_par_r),
      .lit_nxt (lit_nxt[i])
    );
  end

  // visible led drive after the item
  for (genvar j = 0; j < lcfc_pkg::SHOWN_LEDS; j++) begin : g_show
    if (j < LED_COUNT) begin : g_real
      assign led_on_nxt[j] = lit_nxt[j];
    end else begin : g_none
      assign led_on_nxt[j] = 1'b0;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      led_on_r   <= led_on_nxt;
      accepted_r <= accepted;
      ack_r      <= ack;
      ack_sid_r  <= ack ? my_sid_r : '0;
      ack_seq_r  <= ack ? s1_seq_r : '0;
      ack_par_r  <= ack ? s1_par_r : '0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_led_on          = led_on_r;
  assign out_frame_accepted  = accepted_r;
  assign out_ack_valid       = ack_r;
  assign out_ack_security_id = ack_sid_r;
  assign out_ack_seq         = ack_seq_r;
  assign out_ack_parameter   = ack_par_r;

endmodule
`default_nettype wire
